// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the segmenter RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication check, sampled on the rising edge, off during reset
`define BLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("blseg: implication check failed");
// Invariant check, sampled on the rising edge, off during reset
`define BLS_ASSERT_ALW(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("blseg: invariant check failed");
`else
`define BLS_ASSERT_IMP(lbl, ante, cons)
`define BLS_ASSERT_ALW(lbl, cond)
`endif
`endif

// ===== rtl/blseg_pkg.sv =====
// Shared constants, state encodings and handshake structs of the segmenter.
// No dependencies; the divider, span unit and top refer to it by scoped names.
package blseg_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int AW          = 6;   // store address width
    localparam int CNT_W       = 7;   // counts that can hold MAX_SAMPLES
    localparam int SMP_W       = 8;
    localparam int THR_W       = 12;
    localparam int COST_W      = 40;
    localparam int FRAC_W      = 16;
    localparam int NUM_W       = SMP_W + FRAC_W;      // dividend width
    localparam int SUM_W       = 2 * NUM_W + AW;      // exact squared-error sum
    localparam logic [THR_W-1:0] THR_RESET = 12'd10;

    // Top-level sequencer
    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_K0, S_K1, S_K2, S_WAIT, S_AZ1, S_AZ2,
        S_SCAN, S_DECIDE, S_SHK_RD, S_SHK_WR, S_SHC_RD, S_SHC_WR,
        S_RECOMP, S_E0, S_E1, S_E2
    } t_top_state;

    // Span cost unit sequencer
    typedef enum logic [3:0] {
        SP_IDLE, SP_RA, SP_RB, SP_VB, SP_DIV, SP_RD, SP_E, SP_SQ, SP_ACC, SP_DONE
    } t_span_state;

    typedef struct packed {
        logic          start;
        logic [AW-1:0] a;
        logic [AW-1:0] b;
    } t_span_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [COST_W-1:0] cost;
    } t_span_rsp;

endpackage

// ===== rtl/blseg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old word. No dependencies.
module blseg_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/blseg_div.sv =====
// Restoring divider, one quotient bit per cycle, for the segment slope.
// Depends on blseg_pkg for widths.
module blseg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [blseg_pkg::NUM_W-1:0]  i_num,
    input  logic [blseg_pkg::AW-1:0]     i_den,
    output logic                         o_done,
    output logic [blseg_pkg::NUM_W-1:0]  o_quot
);

    logic                        r_busy;
    logic                        r_done;
    logic [4:0]                  r_step;
    logic [blseg_pkg::NUM_W-1:0] r_num;
    logic [blseg_pkg::AW:0]      r_rem;
    logic [blseg_pkg::AW-1:0]    r_den;
    logic [blseg_pkg::AW:0]      rem_sh;
    logic                        q_bit;

    // Trial subtract of the shifted partial remainder
    assign rem_sh = {r_rem[blseg_pkg::AW-1:0], r_num[blseg_pkg::NUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'(blseg_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[blseg_pkg::NUM_W-2:0], q_bit};
            r_rem <= q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== rtl/blseg_span.sv =====
// Span cost unit: squared interpolation error of the samples strictly between
// two kept positions. Depends on blseg_pkg and blseg_div; reads the sample RAM.
module blseg_span (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  blseg_pkg::t_span_req         i_req,
    output blseg_pkg::t_span_rsp         o_rsp,
    output logic [blseg_pkg::AW-1:0]     o_sample_raddr,
    input  logic [blseg_pkg::SMP_W-1:0]  i_sample_rdata
);

    blseg_pkg::t_span_state r_state, n_state;

    logic [blseg_pkg::AW-1:0]     r_a, n_a, r_b, n_b, r_k, n_k;
    logic [blseg_pkg::SMP_W-1:0]  r_va, n_va;
    logic                         r_neg, n_neg;
    logic signed [24:0]           r_slope, n_slope;
    logic signed [25:0]           r_acc, n_acc;
    logic [23:0]                  r_mag, n_mag;
    logic [47:0]                  r_sq, n_sq;
    logic [blseg_pkg::SUM_W-1:0]  r_sum, n_sum;

    logic                         div_start;
    logic [blseg_pkg::NUM_W-1:0]  div_num;
    logic [blseg_pkg::AW-1:0]     div_den;
    logic                         div_done;
    logic [blseg_pkg::NUM_W-1:0]  div_quot;
    logic signed [8:0]            diff;
    logic [7:0]                   diff_mag;
    logic signed [24:0]           slope_v;
    logic signed [25:0]           err;

    blseg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Signed endpoint difference and its magnitude
    assign diff     = $signed({1'b0, i_sample_rdata}) - $signed({1'b0, r_va});
    assign diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
    assign slope_v  = r_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    assign err      = r_acc - $signed({2'b00, i_sample_rdata, 16'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blseg_pkg::SP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_k     <= n_k;
        r_va    <= n_va;
        r_neg   <= n_neg;
        r_slope <= n_slope;
        r_acc   <= n_acc;
        r_mag   <= n_mag;
        r_sq    <= n_sq;
        r_sum   <= n_sum;
    end

    // Sequencer: endpoints, slope divide, then one interior sample per pass
    always_comb begin
        n_state        = r_state;
        n_a            = r_a;
        n_b            = r_b;
        n_k            = r_k;
        n_va           = r_va;
        n_neg          = r_neg;
        n_slope        = r_slope;
        n_acc          = r_acc;
        n_mag          = r_mag;
        n_sq           = r_sq;
        n_sum          = r_sum;
        div_start      = 1'b0;
        div_num        = {diff_mag, 16'b0};
        div_den        = r_b - r_a;
        o_sample_raddr = r_a;
        o_rsp.busy     = (r_state != blseg_pkg::SP_IDLE);
        o_rsp.done     = 1'b0;
        o_rsp.cost     = {2'b00, r_sum[blseg_pkg::SUM_W-1:blseg_pkg::FRAC_W]};
        case (r_state)
            blseg_pkg::SP_IDLE: begin
                if (i_req.start) begin
                    n_a   = i_req.a;
                    n_b   = i_req.b;
                    n_sum = '0;
                    // no interior sample: zero cost
                    if ({1'b0, i_req.b} <= ({1'b0, i_req.a} + 7'd1)) begin
                        n_state = blseg_pkg::SP_DONE;
                    end else begin
                        n_state = blseg_pkg::SP_RA;
                    end
                end
            end
            blseg_pkg::SP_RA: begin
                o_sample_raddr = r_a;
                n_state        = blseg_pkg::SP_RB;
            end
            blseg_pkg::SP_RB: begin
                o_sample_raddr = r_b;
                n_va           = i_sample_rdata;
                n_state        = blseg_pkg::SP_VB;
            end
            blseg_pkg::SP_VB: begin
                n_neg     = diff[8];
                div_start = 1'b1;
                n_state   = blseg_pkg::SP_DIV;
            end
            blseg_pkg::SP_DIV: begin
                if (div_done) begin
                    n_slope = slope_v;
                    n_acc   = $signed({2'b00, r_va, 16'b0}) + 26'(slope_v);
                    n_k     = r_a + 6'd1;
                    n_state = blseg_pkg::SP_RD;
                end
            end
            blseg_pkg::SP_RD: begin
                o_sample_raddr = r_k;
                n_state        = blseg_pkg::SP_E;
            end
            blseg_pkg::SP_E: begin
                n_mag   = err[25] ? 24'(-err) : err[23:0];
                n_state = blseg_pkg::SP_SQ;
            end
            blseg_pkg::SP_SQ: begin
                n_sq    = 48'(r_mag) * 48'(r_mag);
                n_state = blseg_pkg::SP_ACC;
            end
            blseg_pkg::SP_ACC: begin
                n_sum = r_sum + blseg_pkg::SUM_W'(r_sq);
                n_acc = r_acc + 26'(r_slope);
                n_k   = r_k + 6'd1;
                if ((r_k + 6'd1) == r_b) begin
                    n_state = blseg_pkg::SP_DONE;
                end else begin
                    n_state = blseg_pkg::SP_RD;
                end
            end
            blseg_pkg::SP_DONE: begin
                o_rsp.done = 1'b1;
                n_state    = blseg_pkg::SP_IDLE;
            end
            default: begin
                n_state = blseg_pkg::SP_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bottom_up_line_segmenter_unit.sv =====
// Bottom-up line segmenter. Load: one sample word per cycle while loading;
// the last word starts the merge. Merge: init of the kept list, one span
// cost per interior point, then per removal a cost RAM scan, a shift of
// the kept and cost lists and new neighbour costs; run time grows about
// quadratically with n. Results leave through emit states E0, E1, E2, held
// while the output word is not taken. Sync active-low reset; no RAM clear.
`include "assert_macros.svh"

module bottom_up_line_segmenter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [blseg_pkg::SMP_W-1:0]  i_sample,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [blseg_pkg::AW-1:0]     o_point_index,
    output logic [blseg_pkg::SMP_W-1:0]  o_point_value,
    output logic                         o_last_point,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [blseg_pkg::THR_W-1:0]  i_merge_threshold
);

    blseg_pkg::t_top_state r_state, n_state;

    logic [blseg_pkg::CNT_W-1:0]  r_cnt, n_cnt, r_n, n_n, r_kc, n_kc, r_nc, n_nc;
    logic [blseg_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [blseg_pkg::AW-1:0]     r_j, n_j, r_c, n_c, r_a, n_a, r_pos, n_pos;
    logic [blseg_pkg::AW-1:0]     r_ptag, n_ptag;
    logic [blseg_pkg::THR_W-1:0]  r_thr;
    logic [blseg_pkg::COST_W-1:0] r_min, n_min, r_limit, n_limit;
    logic                         r_allzero, n_allzero, r_init, n_init;
    logic                         r_second, n_second, r_pv, n_pv;
    logic                         r_ovalid, n_ovalid;
    logic [blseg_pkg::AW-1:0]     r_opos, n_opos;
    logic [blseg_pkg::SMP_W-1:0]  r_oval, n_oval;
    logic                         r_olast, n_olast;

    logic                         s_we;
    logic [blseg_pkg::AW-1:0]     s_waddr, s_raddr, span_raddr;
    logic [blseg_pkg::SMP_W-1:0]  s_rdata;
    logic                         k_we;
    logic [blseg_pkg::AW-1:0]     k_waddr, k_wdata, k_raddr, k_rdata;
    logic                         c_we;
    logic [blseg_pkg::AW-1:0]     c_waddr, c_raddr;
    logic [blseg_pkg::COST_W-1:0] c_wdata, c_rdata;
    logic [23:0]                  thr_sq;
    logic                         slot_free;

    blseg_pkg::t_span_req span_req;
    blseg_pkg::t_span_rsp span_rsp;

    // Sample store
    blseg_ram #(.W(blseg_pkg::SMP_W), .D(blseg_pkg::MAX_SAMPLES)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (i_sample),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Kept positions
    blseg_ram #(.W(blseg_pkg::AW), .D(blseg_pkg::MAX_SAMPLES)) u_kept_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    // Removal costs
    blseg_ram #(.W(blseg_pkg::COST_W), .D(blseg_pkg::MAX_SAMPLES)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    blseg_span u_span (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (span_req),
        .o_rsp          (span_rsp),
        .o_sample_raddr (span_raddr),
        .i_sample_rdata (s_rdata)
    );

    assign thr_sq    = 24'(r_thr) * 24'(r_thr);
    assign slot_free = !r_ovalid || i_out_ready;
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_ovalid;
    assign o_point_index = r_opos;
    assign o_point_value = r_oval;
    assign o_last_point  = r_olast;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= blseg_pkg::S_LOAD;
            r_cnt    <= '0;
            r_kc     <= '0;
            r_thr    <= blseg_pkg::THR_RESET;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_kc     <= n_kc;
            r_ovalid <= n_ovalid;
            r_pv     <= n_pv;
            if (i_cfg_valid) begin
                r_thr <= i_merge_threshold;
            end
        end
    end

    // Working and output word registers
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_nc      <= n_nc;
        r_idx     <= n_idx;
        r_j       <= n_j;
        r_c       <= n_c;
        r_a       <= n_a;
        r_pos     <= n_pos;
        r_ptag    <= n_ptag;
        r_min     <= n_min;
        r_limit   <= n_limit;
        r_allzero <= n_allzero;
        r_init    <= n_init;
        r_second  <= n_second;
        r_opos    <= n_opos;
        r_oval    <= n_oval;
        r_olast   <= n_olast;
    end

    // Sequencer: load, init costs, merge loop, emit
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_n       = r_n;
        n_kc      = r_kc;
        n_nc      = r_nc;
        n_idx     = r_idx;
        n_j       = r_j;
        n_c       = r_c;
        n_a       = r_a;
        n_pos     = r_pos;
        n_ptag    = r_ptag;
        n_min     = r_min;
        n_limit   = r_limit;
        n_allzero = r_allzero;
        n_init    = r_init;
        n_second  = r_second;
        n_pv      = r_pv;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_opos    = r_opos;
        n_oval    = r_oval;
        n_olast   = r_olast;
        o_in_ready = 1'b0;
        s_we      = 1'b0;
        s_waddr   = r_cnt[blseg_pkg::AW-1:0];
        s_raddr   = span_raddr;
        k_we      = 1'b0;
        k_waddr   = r_idx[blseg_pkg::AW-1:0];
        k_wdata   = r_idx[blseg_pkg::AW-1:0];
        k_raddr   = r_j;
        c_we      = 1'b0;
        c_waddr   = r_j;
        c_wdata   = span_rsp.cost;
        c_raddr   = r_idx[blseg_pkg::AW-1:0];
        span_req.start = 1'b0;
        span_req.a     = r_a;
        span_req.b     = k_rdata;
        case (r_state)
            blseg_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // a full store drops the word but still honors last
                    if (r_cnt < 7'(blseg_pkg::MAX_SAMPLES)) begin
                        s_we  = 1'b1;
                        n_cnt = r_cnt + 7'd1;
                    end
                    if (i_last) begin
                        n_n     = n_cnt;
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_limit = {thr_sq, 16'b0};
                        n_state = blseg_pkg::S_INIT;
                    end
                end
            end
            blseg_pkg::S_INIT: begin
                k_we  = 1'b1;
                n_idx = r_idx + 7'd1;
                if ((r_idx + 7'd1) == r_n) begin
                    n_kc = r_n;
                    if (r_n < 7'd3) begin
                        n_idx   = '0;
                        n_state = blseg_pkg::S_E0;
                    end else begin
                        n_nc      = r_n - 7'd2;
                        n_allzero = 1'b1;
                        n_init    = 1'b1;
                        n_j       = '0;
                        n_state   = blseg_pkg::S_K0;
                    end
                end
            end
            blseg_pkg::S_K0: begin
                k_raddr = r_j;
                n_state = blseg_pkg::S_K1;
            end
            blseg_pkg::S_K1: begin
                n_a     = k_rdata;
                k_raddr = r_j + 6'd2;
                n_state = blseg_pkg::S_K2;
            end
            blseg_pkg::S_K2: begin
                span_req.start = 1'b1;
                n_state        = blseg_pkg::S_WAIT;
            end
            blseg_pkg::S_WAIT: begin
                if (span_rsp.done) begin
                    c_we = 1'b1;
                    if (r_init) begin
                        n_allzero = r_allzero && (span_rsp.cost == '0);
                        if (({1'b0, r_j} + 7'd1) == r_nc) begin
                            n_init = 1'b0;
                            n_idx  = '0;
                            n_pv   = 1'b0;
                            n_state = n_allzero ? blseg_pkg::S_AZ1 : blseg_pkg::S_SCAN;
                        end else begin
                            n_j     = r_j + 6'd1;
                            n_state = blseg_pkg::S_K0;
                        end
                    end else if (!r_second && (r_c != '0)) begin
                        n_j      = r_c - 6'd1;
                        n_second = 1'b1;
                        n_state  = blseg_pkg::S_K0;
                    end else begin
                        n_idx   = '0;
                        n_pv    = 1'b0;
                        n_state = blseg_pkg::S_SCAN;
                    end
                end
            end
            // all-zero costs: keep first, next-to-last and last
            blseg_pkg::S_AZ1: begin
                k_we    = 1'b1;
                k_waddr = 6'd1;
                k_wdata = 6'(r_n - 7'd2);
                n_state = blseg_pkg::S_AZ2;
            end
            blseg_pkg::S_AZ2: begin
                k_we    = 1'b1;
                k_waddr = 6'd2;
                k_wdata = 6'(r_n - 7'd1);
                n_kc    = 7'd3;
                n_idx   = '0;
                n_state = blseg_pkg::S_E0;
            end
            // pipelined minimum scan, first index wins ties
            blseg_pkg::S_SCAN: begin
                if (r_pv && ((r_ptag == '0) || (c_rdata < r_min))) begin
                    n_min = c_rdata;
                    n_c   = r_ptag;
                end
                if (r_idx < r_nc) begin
                    c_raddr = r_idx[blseg_pkg::AW-1:0];
                    n_pv    = 1'b1;
                    n_ptag  = r_idx[blseg_pkg::AW-1:0];
                    n_idx   = r_idx + 7'd1;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = blseg_pkg::S_DECIDE;
                    end
                end
            end
            blseg_pkg::S_DECIDE: begin
                if (r_min >= r_limit) begin
                    n_idx   = '0;
                    n_state = blseg_pkg::S_E0;
                end else begin
                    n_idx   = {1'b0, r_c} + 7'd1;
                    n_state = blseg_pkg::S_SHK_RD;
                end
            end
            // close the gap in the kept list
            blseg_pkg::S_SHK_RD: begin
                if ((r_idx + 7'd1) < r_kc) begin
                    k_raddr = 6'(r_idx + 7'd1);
                    n_state = blseg_pkg::S_SHK_WR;
                end else begin
                    n_idx   = {1'b0, r_c};
                    n_state = blseg_pkg::S_SHC_RD;
                end
            end
            blseg_pkg::S_SHK_WR: begin
                k_we    = 1'b1;
                k_wdata = k_rdata;
                n_idx   = r_idx + 7'd1;
                n_state = blseg_pkg::S_SHK_RD;
            end
            // close the gap in the cost list
            blseg_pkg::S_SHC_RD: begin
                if ((r_idx + 7'd1) < r_nc) begin
                    c_raddr = 6'(r_idx + 7'd1);
                    n_state = blseg_pkg::S_SHC_WR;
                end else begin
                    n_kc = r_kc - 7'd1;
                    n_nc = r_nc - 7'd1;
                    if ((r_kc - 7'd1) == 7'd2) begin
                        n_idx   = '0;
                        n_state = blseg_pkg::S_E0;
                    end else begin
                        n_state = blseg_pkg::S_RECOMP;
                    end
                end
            end
            blseg_pkg::S_SHC_WR: begin
                c_we    = 1'b1;
                c_waddr = r_idx[blseg_pkg::AW-1:0];
                c_wdata = c_rdata;
                n_idx   = r_idx + 7'd1;
                n_state = blseg_pkg::S_SHC_RD;
            end
            // refresh the neighbors of the removed point
            blseg_pkg::S_RECOMP: begin
                n_state = blseg_pkg::S_K0;
                if ({1'b0, r_c} < r_nc) begin
                    n_j      = r_c;
                    n_second = 1'b0;
                end else begin
                    n_j      = r_c - 6'd1;
                    n_second = 1'b1;
                end
            end
            // emit kept points
            blseg_pkg::S_E0: begin
                k_raddr = r_idx[blseg_pkg::AW-1:0];
                n_state = blseg_pkg::S_E1;
            end
            blseg_pkg::S_E1: begin
                s_raddr = k_rdata;
                n_pos   = k_rdata;
                n_state = blseg_pkg::S_E2;
            end
            blseg_pkg::S_E2: begin
                s_raddr = r_pos;
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_opos   = r_pos;
                    n_oval   = s_rdata;
                    n_olast  = ((r_idx + 7'd1) == r_kc);
                    n_idx    = r_idx + 7'd1;
                    if ((r_idx + 7'd1) == r_kc) begin
                        n_kc    = '0;
                        n_state = blseg_pkg::S_LOAD;
                    end else begin
                        n_state = blseg_pkg::S_E0;
                    end
                end
            end
            default: begin
                n_state = blseg_pkg::S_LOAD;
            end
        endcase
    end

    // Checks
    `BLS_ASSERT_IMP(a_ncost_tracks_kept, (r_state == blseg_pkg::S_SCAN), ((r_nc + 7'd2) == r_kc))
    `BLS_ASSERT_IMP(a_span_idle_on_load, o_in_ready, !span_rsp.busy)
    `BLS_ASSERT_ALW(a_count_in_range, (r_cnt <= 7'(blseg_pkg::MAX_SAMPLES)))

endmodule

// ===== verif/tb_bottom_up_line_segmenter_unit.sv =====
// Testbench for the bottom-up line segmenter: directed series, then random series.
// Depends on blseg_pkg and bottom_up_line_segmenter_unit; a predictor checks every word.
module tb_bottom_up_line_segmenter_unit;

    import blseg_pkg::*;

    typedef struct {
        logic [AW-1:0]    idx;
        logic [SMP_W-1:0] val;
        logic             fin;
    } t_point;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [SMP_W-1:0]  i_sample;
    logic              i_last;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [AW-1:0]     o_point_index;
    logic [SMP_W-1:0]  o_point_value;
    logic              o_last_point;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [THR_W-1:0]  i_merge_threshold;

    bottom_up_line_segmenter_unit DUT (.*);

    // predictor state
    logic [SMP_W-1:0]  series [MAX_SAMPLES];
    int                series_len;
    logic [THR_W-1:0]  thr_now;
    t_point            point_q [$];
    int                errors;
    int                burst_left;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // cost of dropping everything between kept positions a and b
    function automatic longint unsigned seg_err(int a, int b);
        longint va, vb, d, slope, interp, e;
        longint unsigned sum;
        va = series[a];
        vb = series[b];
        d = b - a;
        sum = 0;
        if (d <= 0) return 0;
        slope = ((vb - va) * 65536) / d;
        for (int k = a + 1; k < b; k++) begin
            interp = va * 65536 + (k - a) * slope;
            e = interp - longint'(series[k]) * 65536;
            if (e < 0) e = -e;
            sum += longint'(e) * longint'(e);
        end
        sum = sum >> 16;
        return (sum > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : sum;
    endfunction

    // run the merge on the held series and queue the kept points
    task automatic segment_series();
        int                kept [$];
        longint unsigned   cost [$];
        longint unsigned   lim;
        int                n, c;
        bit                allzero;
        n = series_len;
        series_len = 0;
        if (n < 3) begin
            for (int i = 0; i < n; i++)
                point_q.push_back('{i[AW-1:0], series[i], i + 1 == n});
            return;
        end
        allzero = 1;
        for (int i = 0; i < n; i++) kept.push_back(i);
        for (int i = 0; i < n - 2; i++) begin
            cost.push_back(seg_err(i, i + 2));
            if (cost[i] != 0) allzero = 0;
        end
        if (allzero) begin
            point_q.push_back('{6'd0, series[0], 1'b0});
            point_q.push_back('{6'(n - 2), series[n - 2], 1'b0});
            point_q.push_back('{6'(n - 1), series[n - 1], 1'b1});
            return;
        end
        lim = (longint'(thr_now) * thr_now) << 16;
        while (kept.size() > 2) begin
            c = 0;
            for (int i = 1; i < cost.size(); i++)
                if (cost[i] < cost[c]) c = i;
            if (cost[c] >= lim) break;
            kept.delete(c + 1);
            cost.delete(c);
            if (kept.size() == 2) break;
            if (c < cost.size()) cost[c] = seg_err(kept[c], kept[c + 2]);
            if (c > 0) cost[c - 1] = seg_err(kept[c - 1], kept[c + 1]);
        end
        foreach (kept[i])
            point_q.push_back('{kept[i][AW-1:0], series[kept[i]], i + 1 == kept.size()});
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // send one sample word, with bursty random gaps; valid stays high inside a burst
    task automatic send_sample(logic [SMP_W-1:0] smp, logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        i_last     <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        if (series_len < MAX_SAMPLES) begin
            series[series_len] = smp;
            series_len++;
        end
        if (lst) segment_series();
    endtask

    // stop sending and wait until every expected word has come
    task automatic drain();
        i_in_valid <= 1'b0;
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] thr);
        drain();
        i_cfg_valid       <= 1'b1;
        i_merge_threshold <= thr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        thr_now = thr;
    endtask

    // one series; shape: 0 random, 1 ramp, 2 flat, 3 piecewise lines
    task automatic send_series(int len, int shape);
        logic [SMP_W-1:0] v;
        int base, step;
        base = $urandom_range(0, 255);
        step = $urandom_range(0, 12) - 6;
        for (int i = 0; i < len; i++) begin
            case (shape)
                0: v = $urandom_range(0, 255);
                1: v = 8'(base + step * i);
                2: v = 8'(base);
                default: begin
                    if ($urandom_range(0, 7) == 0) step = $urandom_range(0, 20) - 10;
                    base = base + step + $urandom_range(0, 2) - 1;
                    v = 8'(base);
                end
            endcase
            send_sample(v, i == len - 1);
        end
    endtask

    task automatic test_short_series();
        send_sample(8'd0, 1'b1);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b1);
        send_series(3, 0);
    endtask

    task automatic test_flat_and_extremes();
        send_sample(8'd7, 1'b0);
        send_sample(8'd7, 1'b0);
        send_sample(8'd7, 1'b0);
        send_sample(8'd7, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b1);
    endtask

    // more than MAX_SAMPLES words; the tail is dropped
    task automatic test_store_full();
        send_series(MAX_SAMPLES + 3, 3);
        drain();
    endtask

    task automatic test_random_series(int words);
        int sent, len;
        sent = 0;
        while (sent < words) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
            send_series(len, $urandom_range(0, 3));
            sent += len;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (point_q.size() == 0) begin
                report_mismatch("unexpected word", o_point_index, -1);
            end else begin
                want = point_q.pop_front();
                if (o_point_index !== want.idx) report_mismatch("index", o_point_index, want.idx);
                if (o_point_value !== want.val) report_mismatch("value", o_point_value, want.val);
                if (o_last_point !== want.fin) report_mismatch("last", o_last_point, want.fin);
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (($urandom_range(0, 199) / 100) == 1) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        errors = 0; series_len = 0; burst_left = 0; thr_now = THR_RESET;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_sample = '0; i_last = 1'b0;
        i_out_ready = 1'b0; i_cfg_valid = 1'b0; i_merge_threshold = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_series();
        test_flat_and_extremes();
        test_store_full();
        write_threshold(12'd0);
        test_random_series(60);
        write_threshold(12'd4095);
        test_random_series(60);
        write_threshold(12'd1);
        test_random_series(100);
        write_threshold(12'd30);
        test_random_series(120);
        write_threshold(12'd10);
        test_random_series(60);
        drain();
        if (errors == 0 && point_q.size() == 0)
            $display("bottom_up_line_segmenter_unit test passed");
        else
            $display("bottom_up_line_segmenter_unit test failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("bottom_up_line_segmenter_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/blseg_pkg.sv
rtl/blseg_ram.sv
rtl/blseg_div.sv
rtl/blseg_span.sv
rtl/bottom_up_line_segmenter_unit.sv
verif/tb_bottom_up_line_segmenter_unit.sv
